### rtl/ttip_pkg.sv
package ttip_pkg;

  // Width of the consumed-character counter; the count saturates at all ones
  localparam int unsigned OFFSET_BITS = 16;

  localparam int unsigned CH_BITS     = 8;
  localparam int unsigned RADIX_BITS  = 5;
  localparam int unsigned VALUE_BITS  = 32;
  localparam int unsigned OUT_OFS_BITS = 16;
  localparam int unsigned DIGIT_BITS  = 5;

  localparam logic [RADIX_BITS-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_BITS-1:0] BASE_AUTO   = 5'd0;
  localparam logic [RADIX_BITS-1:0] BASE_OCT    = 5'd8;
  localparam logic [RADIX_BITS-1:0] BASE_DEC    = 5'd10;
  localparam logic [RADIX_BITS-1:0] BASE_HEX    = 5'd16;

  // Character codes
  localparam logic [CH_BITS-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_BITS-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_BITS-1:0] CH_LF    = 8'h0a;
  localparam logic [CH_BITS-1:0] CH_VT    = 8'h0b;
  localparam logic [CH_BITS-1:0] CH_FF    = 8'h0c;
  localparam logic [CH_BITS-1:0] CH_CR    = 8'h0d;
  localparam logic [CH_BITS-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CH_BITS-1:0] CH_MINUS = 8'h2d;
  localparam logic [CH_BITS-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_BITS-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_BITS-1:0] CH_LO_A  = 8'h61;
  localparam logic [CH_BITS-1:0] CH_LO_F  = 8'h66;
  localparam logic [CH_BITS-1:0] CH_UP_A  = 8'h41;
  localparam logic [CH_BITS-1:0] CH_UP_F  = 8'h46;
  localparam logic [CH_BITS-1:0] CH_LO_X  = 8'h78;
  localparam logic [CH_BITS-1:0] CH_UP_X  = 8'h58;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SPACE,
    PH_PRE,
    PH_ZERO,
    PH_DIGITS
  } phase_t;

  typedef struct packed {
    logic                  valid;
    logic [DIGIT_BITS-1:0] val;
  } digit_t;

  // Map a character to its hex digit value, if it is one
  function automatic digit_t digit_of(input logic [CH_BITS-1:0] c);
    digit_t d;
    d.valid = 1'b0;
    d.val   = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d.valid = 1'b1;
      d.val   = DIGIT_BITS'(c - CH_ZERO);
    end else if (c >= CH_LO_A && c <= CH_LO_F) begin
      d.valid = 1'b1;
      d.val   = DIGIT_BITS'(c - CH_LO_A + 8'd10);
    end else if (c >= CH_UP_A && c <= CH_UP_F) begin
      d.valid = 1'b1;
      d.val   = DIGIT_BITS'(c - CH_UP_A + 8'd10);
    end
    return d;
  endfunction

  function automatic logic is_space(input logic [CH_BITS-1:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
           (c == CH_CR) || (c == CH_VT) || (c == CH_FF);
  endfunction

endpackage

### rtl/text_to_integer_parser.sv
// The output register loads the result on the edge at which the stop character transfers.
// Throughput: one character per cycle while the output is free; the next parse state and one
// 32x5 multiply-add are combinational. While a result waits unaccepted the input stalls; a
// result taken in the same cycle frees the output register for the next stop character.
// Reset (rst, synchronous): radix returns to 10, the parser goes idle, the output empties.
module text_to_integer_parser
  import ttip_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     radix_we,
  input  logic [RADIX_BITS-1:0]    radix,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [CH_BITS-1:0]       ch,
  input  logic                     first,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [VALUE_BITS-1:0] value,
  output logic [OUT_OFS_BITS-1:0]  end_offset
);

  logic [RADIX_BITS-1:0]  radix_reg;
  phase_t                 phase, phase_next;
  logic                   negative, negative_next;
  logic [VALUE_BITS-1:0]  acc, acc_next;
  logic [RADIX_BITS-1:0]  base, base_next;
  logic [OFFSET_BITS-1:0] consumed, consumed_next;
  logic                   emit;
  logic                   take;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  // Next parse state for the incoming character
  always_comb begin
    phase_t                 ph;
    logic                   neg;
    logic [VALUE_BITS-1:0]  a;
    logic [RADIX_BITS-1:0]  b;
    logic [OFFSET_BITS-1:0] cnt;
    logic                   do_pre;
    logic                   do_dig;
    logic                   bump;
    digit_t                 d;
    logic [VALUE_BITS+RADIX_BITS-1:0] prod;

    ph     = phase;
    neg    = negative;
    a      = acc;
    b      = base;
    cnt    = consumed;
    do_pre = 1'b0;
    do_dig = 1'b0;
    bump   = 1'b0;
    emit   = 1'b0;
    d      = digit_of(ch);
    prod   = '0;

    // A first-marked character restarts the string
    if (first) begin
      ph  = PH_SPACE;
      neg = 1'b0;
      a   = '0;
      b   = radix_reg;
      cnt = '0;
    end

    phase_next = ph;
    unique case (ph)
      PH_SPACE: begin
        if (is_space(ch)) begin
          bump = 1'b1;
        end else if (ch == CH_MINUS || ch == CH_PLUS) begin
          neg        = (ch == CH_MINUS);
          bump       = 1'b1;
          phase_next = PH_PRE;
        end else begin
          do_pre = 1'b1;
        end
      end
      PH_PRE:    do_pre = 1'b1;
      PH_ZERO: begin
        if (ch == CH_LO_X || ch == CH_UP_X) begin
          b          = BASE_HEX;
          a          = '0;
          bump       = 1'b1;
          phase_next = PH_DIGITS;
        end else begin
          do_dig = 1'b1;
        end
      end
      PH_DIGITS: do_dig = 1'b1;
      default:   phase_next = PH_IDLE;
    endcase

    // Prefix handling: leading zero in auto or hex base
    if (do_pre) begin
      if ((b == BASE_AUTO || b == BASE_HEX) && ch == CH_ZERO) begin
        if (b == BASE_AUTO) begin
          b = BASE_OCT;
        end
        a          = '0;
        bump       = 1'b1;
        phase_next = PH_ZERO;
      end else begin
        if (b == BASE_AUTO) begin
          b = BASE_DEC;
        end
        do_dig = 1'b1;
      end
    end

    // Accumulate a digit below the base, else stop
    if (do_dig) begin
      if (d.valid && d.val < b) begin
        prod       = VALUE_BITS'(a) * b + (VALUE_BITS+RADIX_BITS)'(d.val);
        a          = prod[VALUE_BITS-1:0];
        bump       = 1'b1;
        phase_next = PH_DIGITS;
      end else begin
        emit       = 1'b1;
        phase_next = PH_IDLE;
      end
    end

    // Saturating character count
    if (bump && cnt != '1) begin
      cnt = cnt + 1'b1;
    end

    negative_next = neg;
    acc_next      = a;
    base_next     = b;
    consumed_next = cnt;
  end

  // Hold radix, advance parse state on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      radix_reg <= RADIX_RESET;
      phase     <= PH_IDLE;
      negative  <= 1'b0;
      acc       <= '0;
      base      <= '0;
      consumed  <= '0;
    end else begin
      if (radix_we) begin
        radix_reg <= radix;
      end
      if (take) begin
        phase    <= phase_next;
        negative <= negative_next;
        acc      <= acc_next;
        base     <= base_next;
        consumed <= consumed_next;
      end
    end
  end

  // Output register: load on a stopping transfer, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      value      <= negative_next ? -$signed(acc_next) : $signed(acc_next);
      end_offset <= OUT_OFS_BITS'(consumed_next);
    end
  end

endmodule

### test/text_to_integer_parser_tb.sv
module text_to_integer_parser_tb;
  import ttip_pkg::*;

  typedef struct packed {
    logic [CH_BITS-1:0] ch;
    logic               first;
  } char_item_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic [OUT_OFS_BITS-1:0]      offset;
  } parse_result_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         radix_we = 1'b0;
  logic [RADIX_BITS-1:0]        radix = '0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [CH_BITS-1:0]           ch = '0;
  logic                         first = 1'b0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic signed [VALUE_BITS-1:0] value;
  logic [OUT_OFS_BITS-1:0]      end_offset;

  text_to_integer_parser uut (
    .clk        (clk),
    .rst        (rst),
    .radix_we   (radix_we),
    .radix      (radix),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .ch         (ch),
    .first      (first),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .value      (value),
    .end_offset (end_offset)
  );

  always #1 clk = ~clk;

  // Characters waiting to go out and parse results waiting to come back
  char_item_t    char_queue[$];
  parse_result_t result_queue[$];

  int err_count = 0;
  int sent_count = 0;
  int checked_count = 0;
  int radix_settings = 0;

  int send_gap = 0;
  int send_burst = 0;
  int recv_gap = 0;
  int recv_burst = 0;

  logic [CH_BITS-1:0] ws_set [6] = '{CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_VT, CH_FF};

  // Parser state as the testbench sees it
  logic [RADIX_BITS-1:0]  model_radix = RADIX_RESET;
  phase_t                 p_phase = PH_IDLE;
  logic                   p_neg = 1'b0;
  logic [VALUE_BITS-1:0]  p_acc = '0;
  logic [RADIX_BITS-1:0]  p_base = '0;
  logic [OFFSET_BITS-1:0] p_count = '0;

  function automatic int hex_digit_value(input logic [CH_BITS-1:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
    if (c >= CH_LO_A && c <= CH_LO_F) return int'(c - CH_LO_A) + 10;
    if (c >= CH_UP_A && c <= CH_UP_F) return int'(c - CH_UP_A) + 10;
    return -1;
  endfunction

  function automatic void bump_count();
    if (p_count != '1) p_count = p_count + 1'b1;
  endfunction

  // Advance the parser by one character; queue a result at the stop character
  function automatic void parse_char(input logic [CH_BITS-1:0] c, input logic f);
    logic          try_pre;
    logic          try_dig;
    int            dv;
    parse_result_t res;
    try_pre = 1'b0;
    try_dig = 1'b0;
    if (f) begin
      p_phase = PH_SPACE;
      p_neg   = 1'b0;
      p_acc   = '0;
      p_base  = model_radix;
      p_count = '0;
    end
    case (p_phase)
      PH_SPACE: begin
        if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR ||
            c == CH_VT || c == CH_FF) begin
          bump_count();
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          p_neg = (c == CH_MINUS);
          bump_count();
          p_phase = PH_PRE;
        end else begin
          try_pre = 1'b1;
        end
      end
      PH_PRE: try_pre = 1'b1;
      PH_ZERO: begin
        if (c == CH_LO_X || c == CH_UP_X) begin
          p_base = BASE_HEX;
          p_acc  = '0;
          bump_count();
          p_phase = PH_DIGITS;
        end else begin
          try_dig = 1'b1;
        end
      end
      PH_DIGITS: try_dig = 1'b1;
      default: p_phase = PH_IDLE;
    endcase
    // Leading zero: octal in auto mode, possible 0x prefix in auto or hex mode
    if (try_pre) begin
      if (p_base == BASE_AUTO || p_base == BASE_HEX) begin
        if (c == CH_ZERO) begin
          if (p_base == BASE_AUTO) p_base = BASE_OCT;
          p_acc = '0;
          bump_count();
          p_phase = PH_ZERO;
        end else begin
          if (p_base == BASE_AUTO) p_base = BASE_DEC;
          try_dig = 1'b1;
        end
      end else begin
        try_dig = 1'b1;
      end
    end
    if (try_dig) begin
      dv = hex_digit_value(c);
      if (dv >= 0 && dv < int'(p_base)) begin
        p_acc = p_acc * VALUE_BITS'(p_base) + VALUE_BITS'(dv);
        bump_count();
        p_phase = PH_DIGITS;
      end else begin
        res.value  = p_neg ? -p_acc : p_acc;
        res.offset = OUT_OFS_BITS'(p_count);
        result_queue.push_back(res);
        p_phase = PH_IDLE;
      end
    end
  endfunction

  // Idle cycles before the next transfer, with occasional stretches of none
  function automatic int draw_wait(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 7);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got %08h, expected %08h", $time, what, got, want);
    err_count++;
  endtask

  // Drive characters; predict each one as it transfers
  always @(posedge clk) begin
    logic       nv;
    char_item_t item;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      nv = in_valid;
      if (in_valid && in_ready) begin
        parse_char(ch, first);
        sent_count++;
        nv = 1'b0;
      end
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end else if (char_queue.size() > 0) begin
          item = char_queue.pop_front();
          ch    <= item.ch;
          first <= item.first;
          nv = 1'b1;
          send_gap <= draw_wait(send_burst);
        end
      end
      in_valid <= nv;
    end
  end

  // Accept results with random stalls and check them in order
  always @(posedge clk) begin
    parse_result_t want;
    int            w;
    if (rst) begin
      out_ready <= 1'b0;
      recv_gap  <= 0;
    end else if (out_valid && out_ready) begin
      if (result_queue.size() == 0) begin
        report_mismatch("result with none expected", value, 32'h0);
      end else begin
        want = result_queue.pop_front();
        if (value !== want.value) report_mismatch("value", value, want.value);
        if (end_offset !== want.offset)
          report_mismatch("end_offset", 32'(end_offset), 32'(want.offset));
      end
      checked_count++;
      w = draw_wait(recv_burst);
      if (w == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        recv_gap  <= w - 1;
      end
    end else if (!out_ready) begin
      if (recv_gap > 0) recv_gap <= recv_gap - 1;
      else out_ready <= 1'b1;
    end
  end

  function automatic void push_char(input logic [CH_BITS-1:0] c, input logic f);
    char_item_t item;
    item.ch    = c;
    item.first = f;
    char_queue.push_back(item);
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i], i == 0);
  endfunction

  function automatic logic [CH_BITS-1:0] digit_char(input int dv);
    if (dv < 10) return CH_ZERO + CH_BITS'(dv);
    if ($urandom_range(0, 1) == 0) return CH_LO_A + CH_BITS'(dv - 10);
    return CH_UP_A + CH_BITS'(dv - 10);
  endfunction

  // Queue one string: mostly well formed with random content, some noise
  function automatic void push_random_string(input logic [RADIX_BITS-1:0] base,
                                             inout int counted);
    int   style;
    int   n;
    int   eff;
    int   lim;
    int   dv;
    logic lead;
    style = $urandom_range(0, 9);
    lead  = 1'b1;
    if (style == 0) begin
      // Noise: arbitrary characters, possibly a string cut short by the next one
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
        push_char(CH_BITS'($urandom_range(0, 255)), lead);
        lead = 1'b0;
        counted++;
      end
      return;
    end
    if ($urandom_range(0, 2) == 0) begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) begin
        push_char(ws_set[$urandom_range(0, 5)], lead);
        lead = 1'b0;
        counted++;
      end
    end
    case ($urandom_range(0, 3))
      0: begin push_char(CH_PLUS, lead); lead = 1'b0; counted++; end
      1: begin push_char(CH_MINUS, lead); lead = 1'b0; counted++; end
      default: ;
    endcase
    eff = int'(base);
    if (base == BASE_AUTO || base == BASE_HEX) begin
      case ($urandom_range(0, 3))
        0: begin
          push_char(CH_ZERO, lead);
          push_char($urandom_range(0, 1) ? CH_LO_X : CH_UP_X, 1'b0);
          lead = 1'b0;
          counted += 2;
          eff = 16;
        end
        1: begin
          push_char(CH_ZERO, lead);
          lead = 1'b0;
          counted++;
          eff = (base == BASE_AUTO) ? 8 : 16;
        end
        default: eff = (base == BASE_AUTO) ? 10 : 16;
      endcase
    end
    lim = (eff > 16) ? 16 : ((eff < 1) ? 1 : eff);
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 5);
    for (int i = 0; i < n; i++) begin
      dv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, lim - 1);
      push_char(digit_char(dv), lead);
      lead = 1'b0;
      counted++;
    end
    // Terminate: NUL or any character; some strings run on into the next one
    if ($urandom_range(0, 2) == 0) push_char(8'h00, lead);
    else push_char(CH_BITS'($urandom_range(0, 255)), lead);
    counted++;
    // Trailing characters after the stop are dropped by the block
    if (style == 1) begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) push_char(CH_BITS'($urandom_range(0, 255)), 1'b0);
    end
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (char_queue.size() != 0 || in_valid || result_queue.size() != 0);
    repeat (3) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_radix(input logic [RADIX_BITS-1:0] r);
    @(posedge clk);
    radix_we <= 1'b1;
    radix    <= r;
    model_radix = r;
    @(posedge clk);
    radix_we <= 1'b0;
    radix_settings++;
    @(negedge clk);
  endtask

  initial begin
    logic [RADIX_BITS-1:0] plan [12];
    int counted;
    plan = '{BASE_AUTO, BASE_HEX, BASE_OCT, 5'd1, 5'd2, 5'd31, 5'd17, BASE_DEC,
             5'd0, 5'd0, 5'd0, 5'd0};
    for (int i = 8; i < 12; i++) plan[i] = RADIX_BITS'($urandom_range(0, 31));
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed strings at the reset radix
    push_char("Z", 1'b0);
    push_text(" \t-42");
    push_char(8'h00, 1'b0);
    push_text("+,");
    push_text("12");
    push_text("7");
    push_char(8'hff, 1'b0);
    wait_idle();

    // Hex prefix with no digits, then a value that wraps
    set_radix(BASE_HEX);
    push_text("0xg");
    push_text("Fffffffff");
    push_char(8'h00, 1'b0);
    wait_idle();

    // Random strings over a walk of radix settings
    for (int p = 0; p < 12; p++) begin
      set_radix(plan[p]);
      counted = 0;
      while (counted < 105) push_random_string(plan[p], counted);
      wait_idle();
    end

    repeat (10) @(posedge clk);
    $display("Sent %0d characters under %0d radix settings; %0d parse results checked.",
             sent_count, radix_settings + 1, checked_count);
    if (err_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
